/* hdl/lfu_pkg.sv */
// Shared types and constants for the LFU cache with LRU tie-break.
package lfu_pkg;

    localparam int CMD_BITS   = 1;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan_start;   // clear scan results, point at entry 0
        logic scan_step;    // examine one entry
        logic commit;       // apply the update found by the scan
    } lfu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;    // the entry examined now is the last one
    } lfu_status_t;

endpackage

/* hdl/lfu_cache_lru_tiebreak_unit.sv */
// Top level of the LFU cache with LRU tie-break.
//
// Usage: each request on the s_axis channel is a get or a put of a key.
// s_axis_tdata carries {value, key, cmd}; m_axis_tdata returns
// {evicted_key, evicted, data, hit} for each request, one result each.
// A request runs from acceptance to result in these steps: the datapath
// examines one entry per cycle for the key match, the least-used oldest
// victim and a free slot, waits until the result register is free, then
// applies the update as it loads the result.
// One request is in work at a time; the next is accepted in the cycle after
// the result is loaded. The result register holds while m_axis_tready is
// low; the update waits until the register is free. Capacity is written
// through cfg_we/cfg_data; the user must write it only while idle, the
// block itself does not enforce this. Above ENTRIES it acts as ENTRIES,
// zero blocks inserts.
// Reset empties the cache and sets capacity to 16.
module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16,
    parameter int USE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // cmd[0], key[16:1], value[48:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // hit[0], data[32:1], evicted[33], evicted_key[49:34]
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data
);

    logic [lfu_pkg::CAP_BITS-1:0] cap_reg;
    lfu_pkg::lfu_cmd_t    cmd;
    lfu_pkg::lfu_status_t status;
    logic in_fire, load_out, out_free;
    logic res_hit, res_evicted;
    logic [31:0] res_data;
    logic [KEY_BITS-1:0] res_evk;
    logic [55:0] out_reg;
    logic out_valid_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lfu_pkg::CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_data;
    end

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_axis_tready),
        .load_out (load_out)
    );

    lfu_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .USE_BITS (USE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .capacity        (cap_reg),
        .in_put          (s_axis_tdata[0]),
        .in_key          (KEY_BITS'(s_axis_tdata[16:1])),
        .in_value        (s_axis_tdata[48:17]),
        .res_hit         (res_hit),
        .res_data        (res_data),
        .res_evicted     (res_evicted),
        .res_evicted_key (res_evk)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= {6'd0, 16'(res_evk), res_evicted, res_data, res_hit};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

/* hdl/lfu_ctrl.sv */
// Controller: sequences the scan, the commit and the response of one request.
module lfu_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_free,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    cmd,
    output logic                 in_ready,
    output logic                 load_out
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_WAIT} state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/lfu_datapath.sv */
// Datapath: entry storage, serial match and victim scan, and the update.
module lfu_datapath #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16,
    parameter int USE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_status_t          status,
    input  logic [lfu_pkg::CAP_BITS-1:0]  capacity,
    input  logic                          in_put,
    input  logic [KEY_BITS-1:0]           in_key,
    input  logic [lfu_pkg::VALUE_BITS-1:0] in_value,
    output logic                          res_hit,
    output logic [lfu_pkg::VALUE_BITS-1:0] res_data,
    output logic                          res_evicted,
    output logic [KEY_BITS-1:0]           res_evicted_key
);

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam logic [USE_BITS-1:0] USE_MAX = '1;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    // Entry storage; age 0 is the youngest.
    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_BITS-1:0] key_reg   [ENTRIES];
    logic [lfu_pkg::VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [USE_BITS-1:0] uses_reg  [ENTRIES];
    logic [IDX_BITS-1:0] age_reg   [ENTRIES];
    logic [CNT_BITS-1:0] fill_reg;

    // Request and scan registers.
    logic                 put_reg;
    logic [KEY_BITS-1:0]  rkey_reg;
    logic [lfu_pkg::VALUE_BITS-1:0] rval_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic                 found_reg, vic_ok_reg, free_ok_reg;
    logic [IDX_BITS-1:0]  found_idx_reg, vic_idx_reg, free_idx_reg;

    assign status.scan_last = (idx_reg == LAST_IDX);

    // Serial scan over one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (!status.scan_last)
                idx_reg <= idx_reg + 1'b1;
            if (valid_reg[idx_reg])
            begin
                if (!found_reg && key_reg[idx_reg] == rkey_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= idx_reg;
                end
                if (!vic_ok_reg || uses_reg[idx_reg] < uses_reg[vic_idx_reg] ||
                    (uses_reg[idx_reg] == uses_reg[vic_idx_reg] &&
                     age_reg[idx_reg] > age_reg[vic_idx_reg]))
                begin
                    vic_ok_reg  <= 1'b1;
                    vic_idx_reg <= idx_reg;
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= idx_reg;
            end
        end
    end

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            put_reg  <= in_put;
            rkey_reg <= in_key;
            rval_reg <= in_value;
        end
    end

    // Decision for the commit.
    logic [CNT_BITS-1:0] cap;
    logic                do_evict, do_insert, do_touch;
    logic [IDX_BITS-1:0] slot, touch_age, vic_age;

    always_comb
    begin
        if (32'(capacity) > ENTRIES)
            cap = CNT_BITS'(ENTRIES);
        else
            cap = CNT_BITS'(capacity);
        do_touch  = found_reg && (put_reg == lfu_pkg::CMD_GET || cap != '0);
        do_evict  = put_reg && !found_reg && cap != '0 && fill_reg >= cap && vic_ok_reg;
        do_insert = put_reg && !found_reg && cap != '0 && (do_evict || free_ok_reg);
        slot      = do_evict ? vic_idx_reg : free_idx_reg;
        touch_age = age_reg[found_idx_reg];
        vic_age   = age_reg[vic_idx_reg];
        res_hit         = found_reg;
        res_data        = (found_reg && put_reg == lfu_pkg::CMD_GET) ?
                          value_reg[found_idx_reg] : '0;
        res_evicted     = do_evict;
        res_evicted_key = do_evict ? key_reg[vic_idx_reg] : '0;
    end

    // Apply the update to every entry at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_insert)
            begin
                valid_reg[slot] <= 1'b1;
                if (!do_evict)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (do_touch && valid_reg[j])
                begin
                    if (IDX_BITS'(j) == found_idx_reg)
                        age_reg[j] <= '0;
                    else if (age_reg[j] < touch_age)
                        age_reg[j] <= age_reg[j] + 1'b1;
                end
                else if (do_insert && valid_reg[j] && IDX_BITS'(j) != slot)
                begin
                    if (!do_evict || age_reg[j] < vic_age)
                        age_reg[j] <= age_reg[j] + 1'b1;
                end
            end
            if (do_touch)
            begin
                if (uses_reg[found_idx_reg] != USE_MAX)
                    uses_reg[found_idx_reg] <= uses_reg[found_idx_reg] + 1'b1;
                if (put_reg)
                    value_reg[found_idx_reg] <= rval_reg;
            end
            if (do_insert)
            begin
                key_reg[slot]   <= rkey_reg;
                value_reg[slot] <= rval_reg;
                uses_reg[slot]  <= USE_BITS'(1);
                age_reg[slot]   <= '0;
            end
        end
    end

endmodule
